// File: hw/rtl/ihex_pkg.sv
// ----------------------------------------------------------------------------
// ihex_pkg
// Shared types, codes and helpers for the Intel HEX record decoder.
// ----------------------------------------------------------------------------
package ihex_pkg;

  // The character that opens every record.
  localparam logic [7:0] START_CHAR = 8'h3A;

  // The highest record type that is accepted.
  localparam logic [7:0] MAX_TYPE = 8'h05;

  // Parse phases of one record.
  typedef enum logic [2:0] {
    PH_COLON = 3'd0,
    PH_COUNT = 3'd1,
    PH_ADDR  = 3'd2,
    PH_TYPE  = 3'd3,
    PH_DATA  = 3'd4,
    PH_CSUM  = 3'd5,
    PH_DONE  = 3'd6,
    PH_SKIP  = 3'd7
  } phase_t;

  // Record status codes carried in the summary.
  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOCOLON = 3'd1,
    ST_DIGIT   = 3'd2,
    ST_TYPE    = 3'd3,
    ST_LENGTH  = 3'd4,
    ST_CSUM    = 3'd5
  } status_t;

  // Result kinds.
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // One result word as held in the output register.
  typedef struct packed {
    logic        result_kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [7:0]  declared_count;
    logic [15:0] load_address;
    logic [7:0]  record_type;
    logic [7:0]  checksum_field;
    status_t     status;
  } result_t;

  // Decoded hex digit with a flag telling whether the character is one.
  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } nibble_t;

  // Map an ASCII character to its hex digit value.
  function automatic nibble_t hex_value(input logic [7:0] c);
    nibble_t n;
    n.valid = 1'b1;
    n.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      n.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      n.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      n.value = 4'(c - 8'h37);
    end else begin
      n.valid = 1'b0;
    end
    return n;
  endfunction

endpackage

// File: hw/rtl/ihex_in_if.sv
// ----------------------------------------------------------------------------
// ihex_in_if
// Character channel into the decoder: one ASCII character per word.
// ----------------------------------------------------------------------------
interface ihex_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_record;

  modport source (output valid, output char_code, output end_of_record, input ready);
  modport sink   (input valid, input char_code, input end_of_record, output ready);
endinterface

// File: hw/rtl/ihex_out_if.sv
// ----------------------------------------------------------------------------
// ihex_out_if
// Result channel out of the decoder: a data byte or a record summary per word.
// ----------------------------------------------------------------------------
interface ihex_out_if;
  logic        valid;
  logic        ready;
  logic        result_kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic [7:0]  declared_count;
  logic [15:0] load_address;
  logic [7:0]  record_type;
  logic [7:0]  checksum_field;
  logic [2:0]  status;

  modport source (
    output valid, output result_kind, output data_byte, output byte_index,
    output declared_count, output load_address, output record_type,
    output checksum_field, output status, input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input byte_index,
    input declared_count, input load_address, input record_type,
    input checksum_field, input status, output ready
  );
endinterface

// File: hw/rtl/intel_hex_record_decoder_top.sv
// The decoder takes one character word per clock cycle, back to back, while
// the output is not stalled, and gives at most one result word for each: a
// data byte with its index, or, on the character flagged as the end of the
// record, a summary with the record's fields and its status. A character
// first lands in an input register; when the output can take a word, the
// parser state is updated and any result is written to the output register.
// The input register lets one more character in while a result waits on a
// stalled output. Sustained rate is one character per cycle while the output
// is not stalled.
// ----------------------------------------------------------------------------
// intel_hex_record_decoder_top
// Intel HEX record parser: decodes ASCII records into data bytes and a
// per-record summary with count, address, type, checksum and status.
// ----------------------------------------------------------------------------
module intel_hex_record_decoder_top (
  input  logic         clk,
  input  logic         rst_n,
  ihex_in_if.sink      in_chan,
  ihex_out_if.source   out_chan
);
  import ihex_pkg::*;

  // Input register.
  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_eor_r;

  // Parser state.
  phase_t     phase_r, phase_nxt;
  logic [3:0] pend_nib_r, pend_nib_nxt;
  logic       nib_pend_r, nib_pend_nxt;
  logic       addr_cnt_r, addr_cnt_nxt;
  logic [7:0] count_r, count_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0] type_r, type_nxt;
  logic [7:0] data_cnt_r, data_cnt_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] csum_r, csum_nxt;
  status_t    err_r, err_nxt;

  // Output register.
  logic       out_valid_r;
  result_t    res_r, res_nxt;
  logic       emit;

  logic       advance;
  nibble_t    nib;
  logic [7:0] byte_val;
  logic [7:0] data_cnt_inc;

  // The parser moves when a character is held and the output can take a word.
  assign advance        = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !in_valid_r || advance;

  // Input register load.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
    if (in_chan.ready && in_chan.valid) begin
      in_char_r <= in_chan.char_code;
      in_eor_r  <= in_chan.end_of_record;
    end
  end

  assign nib          = hex_value(in_char_r);
  assign byte_val     = {pend_nib_r, nib.value};
  assign data_cnt_inc = data_cnt_r + 8'd1;

  // Next parser state and result for the held character.
  always_comb begin
    phase_nxt    = phase_r;
    pend_nib_nxt = pend_nib_r;
    nib_pend_nxt = nib_pend_r;
    addr_cnt_nxt = addr_cnt_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    type_nxt     = type_r;
    data_cnt_nxt = data_cnt_r;
    sum_nxt      = sum_r;
    csum_nxt     = csum_r;
    err_nxt      = err_r;
    emit         = 1'b0;
    res_nxt      = '0;

    case (phase_r)
      PH_COLON: begin
        if (in_char_r == START_CHAR) begin
          phase_nxt = PH_COUNT;
        end else begin
          if (err_r == ST_OK) err_nxt = ST_NOCOLON;
          phase_nxt = PH_SKIP;
        end
      end
      PH_DONE: begin
        // Anything after the checksum byte makes the record too long.
        if (err_r == ST_OK) err_nxt = ST_LENGTH;
        phase_nxt = PH_SKIP;
      end
      PH_SKIP: begin
        // Ignore the rest of a failed record.
      end
      default: begin
        if (!nib.valid) begin
          if (err_r == ST_OK) err_nxt = ST_DIGIT;
          phase_nxt = PH_SKIP;
        end else if (!nib_pend_r) begin
          pend_nib_nxt = nib.value;
          nib_pend_nxt = 1'b1;
        end else begin
          nib_pend_nxt = 1'b0;
          sum_nxt      = sum_r + byte_val;
          case (phase_r)
            PH_COUNT: begin
              count_nxt    = byte_val;
              addr_cnt_nxt = 1'b0;
              phase_nxt    = PH_ADDR;
            end
            PH_ADDR: begin
              addr_nxt = {addr_r[7:0], byte_val};
              if (addr_cnt_r) begin
                addr_cnt_nxt = 1'b0;
                phase_nxt    = PH_TYPE;
              end else begin
                addr_cnt_nxt = 1'b1;
              end
            end
            PH_TYPE: begin
              type_nxt     = byte_val;
              data_cnt_nxt = 8'd0;
              if (byte_val > MAX_TYPE) begin
                if (err_r == ST_OK) err_nxt = ST_TYPE;
                phase_nxt = PH_SKIP;
              end else begin
                phase_nxt = (count_r != 8'd0) ? PH_DATA : PH_CSUM;
              end
            end
            PH_DATA: begin
              emit                = 1'b1;
              res_nxt.result_kind = KIND_DATA;
              res_nxt.data_byte   = byte_val;
              res_nxt.byte_index  = data_cnt_r;
              data_cnt_nxt        = data_cnt_inc;
              if (data_cnt_inc == count_r) phase_nxt = PH_CSUM;
            end
            default: begin
              csum_nxt  = byte_val;
              phase_nxt = PH_DONE;
            end
          endcase
        end
      end
    endcase

    // The last character of a record gives the summary and clears the parser.
    if (in_eor_r) begin
      emit                   = 1'b1;
      res_nxt                = '0;
      res_nxt.result_kind    = KIND_SUMMARY;
      res_nxt.declared_count = count_nxt;
      res_nxt.load_address   = addr_nxt;
      res_nxt.record_type    = type_nxt;
      res_nxt.checksum_field = csum_nxt;
      if (err_nxt != ST_OK) begin
        res_nxt.status = err_nxt;
      end else if (phase_nxt != PH_DONE) begin
        res_nxt.status = ST_LENGTH;
      end else if (sum_nxt != 8'd0) begin
        res_nxt.status = ST_CSUM;
      end else begin
        res_nxt.status = ST_OK;
      end
      phase_nxt    = PH_COLON;
      pend_nib_nxt = 4'd0;
      nib_pend_nxt = 1'b0;
      addr_cnt_nxt = 1'b0;
      count_nxt    = 8'd0;
      addr_nxt     = 16'd0;
      type_nxt     = 8'd0;
      data_cnt_nxt = 8'd0;
      sum_nxt      = 8'd0;
      csum_nxt     = 8'd0;
      err_nxt      = ST_OK;
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_COLON;
      pend_nib_r <= 4'd0;
      nib_pend_r <= 1'b0;
      addr_cnt_r <= 1'b0;
      count_r    <= 8'd0;
      addr_r     <= 16'd0;
      type_r     <= 8'd0;
      data_cnt_r <= 8'd0;
      sum_r      <= 8'd0;
      csum_r     <= 8'd0;
      err_r      <= ST_OK;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      pend_nib_r <= pend_nib_nxt;
      nib_pend_r <= nib_pend_nxt;
      addr_cnt_r <= addr_cnt_nxt;
      count_r    <= count_nxt;
      addr_r     <= addr_nxt;
      type_r     <= type_nxt;
      data_cnt_r <= data_cnt_nxt;
      sum_r      <= sum_nxt;
      csum_r     <= csum_nxt;
      err_r      <= err_nxt;
    end
  end

  // Output register: a taken word leaves, a new result word loads.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && emit) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.result_kind    = res_r.result_kind;
  assign out_chan.data_byte      = res_r.data_byte;
  assign out_chan.byte_index     = res_r.byte_index;
  assign out_chan.declared_count = res_r.declared_count;
  assign out_chan.load_address   = res_r.load_address;
  assign out_chan.record_type    = res_r.record_type;
  assign out_chan.checksum_field = res_r.checksum_field;
  assign out_chan.status         = res_r.status;

endmodule
